// File: hdl/sha256_pkg.sv
// shared types and constants for the byte-stream sha-256 hasher
// no dependencies; imported by the controller, the datapath and the top level
`default_nettype none

package sha256_pkg;

    localparam int WORD_W  = 32;
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 64;
    localparam int NUM_WORDS = 16;
    localparam int NUM_HASH  = 8;
    localparam int CNT_W   = 6;
    localparam int RND_W   = 6;
    localparam int IDX_W   = 3;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 40;

    localparam logic [CNT_W-1:0] CNT_LAST   = 6'd63;
    localparam logic [CNT_W-1:0] CNT_LEN    = 6'd56;
    localparam logic [RND_W-1:0] RND_LAST   = 6'd63;
    localparam logic [IDX_W-1:0] IDX_LAST   = 3'd7;
    localparam logic [BYTE_W-1:0] PAD_MARK_BYTE = 8'h80;
    localparam logic [LEN_W-1:0] BYTE_BITS  = 64'd8;

    localparam logic [WORD_W-1:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [WORD_W-1:0] INIT_H [NUM_HASH] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD_MARK,
        ST_PAD_ZERO,
        ST_PAD_LEN,
        ST_COMPRESS,
        ST_FINAL_ADD,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        SRC_DATA,
        SRC_MARK,
        SRC_ZERO,
        SRC_LEN
    } byte_src_t;

    typedef struct packed {
        logic      shift_en;
        byte_src_t src;
        logic      count_len;
        logic      round_en;
        logic      final_add;
        logic      out_load;
        logic      reinit;
    } dp_cmd_t;

    typedef struct packed {
        logic cnt_last;
        logic cnt_at_len;
        logic round_last;
        logic word_last;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// File: hdl/sha256_ctrl.sv
// controller state machine: byte intake, padding sequence, round loop, digest readout
// depends on sha256_pkg
`default_nettype none

module sha256_ctrl
    import sha256_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    input  wire logic       s_tuser,
    input  wire logic       s_tlast,
    output logic            s_tready,
    input  wire dp_status_t sts,
    output dp_cmd_t         cmd
);

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_tuser) begin
                        cmd.shift_en  = 1'b1;
                        cmd.src       = SRC_DATA;
                        cmd.count_len = 1'b1;
                    end
                    if (s_tuser && sts.cnt_last) begin
                        state_next = ST_COMPRESS;
                        ret_next   = s_tlast ? ST_PAD_MARK : ST_IDLE;
                    end else if (s_tlast) begin
                        state_next = ST_PAD_MARK;
                    end
                end
            end
            ST_PAD_MARK: begin
                cmd.shift_en = 1'b1;
                cmd.src      = SRC_MARK;
                state_next   = ST_PAD_ZERO;
                if (sts.cnt_last) begin
                    state_next = ST_COMPRESS;
                    ret_next   = ST_PAD_ZERO;
                end
            end
            ST_PAD_ZERO: begin
                if (sts.cnt_at_len) begin
                    state_next = ST_PAD_LEN;
                end else begin
                    cmd.shift_en = 1'b1;
                    cmd.src      = SRC_ZERO;
                    if (sts.cnt_last) begin
                        state_next = ST_COMPRESS;
                        ret_next   = ST_PAD_ZERO;
                    end
                end
            end
            ST_PAD_LEN: begin
                cmd.shift_en = 1'b1;
                cmd.src      = SRC_LEN;
                if (sts.cnt_last) begin
                    state_next = ST_COMPRESS;
                    ret_next   = ST_OUT;
                end
            end
            ST_COMPRESS: begin
                cmd.round_en = 1'b1;
                if (sts.round_last) begin
                    state_next = ST_FINAL_ADD;
                end
            end
            ST_FINAL_ADD: begin
                cmd.final_add = 1'b1;
                state_next    = ret_reg;
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    if (sts.word_last) begin
                        cmd.reinit = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/sha256_dp.sv
// datapath: 16-word block/schedule window, round registers, hash state,
// bit length counter and the digest output register; depends on sha256_pkg
`default_nettype none

module sha256_dp
    import sha256_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic [BYTE_W-1:0]     data_byte,
    input  wire dp_cmd_t               cmd,
    output dp_status_t                 sts,
    input  wire logic                  m_tready,
    output logic                       m_tvalid,
    output logic [M_TDATA_W-1:0]       m_tdata,
    output logic                       m_tlast
);

    function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x, input int n);
        rotr = (x >> n) | (x << (WORD_W - n));
    endfunction

    logic [WORD_W-1:0] blk_reg [NUM_WORDS];
    logic [WORD_W-1:0] v_reg   [NUM_HASH];
    logic [WORD_W-1:0] h_reg   [NUM_HASH];
    logic [CNT_W-1:0]  cnt_reg;
    logic [RND_W-1:0]  rnd_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              out_valid_reg;
    logic [WORD_W-1:0] out_word_reg;
    logic [IDX_W-1:0]  out_idx_reg;

    logic [BYTE_W-1:0] in_byte;
    logic [LEN_W-1:0]  len_shifted;
    logic [WORD_W-1:0] sched_new, t1, t2, ch, maj, sig0, sig1, ssig0, ssig1;

    // length bytes go out most significant first while the count runs 56..63
    assign len_shifted = len_reg >> {~cnt_reg[2:0], 3'b000};

    always_comb begin
        case (cmd.src)
            SRC_DATA: in_byte = data_byte;
            SRC_MARK: in_byte = PAD_MARK_BYTE;
            SRC_ZERO: in_byte = '0;
            SRC_LEN:  in_byte = len_shifted[BYTE_W-1:0];
            default:  in_byte = '0;
        endcase
    end

    always_comb begin
        ssig0 = rotr(blk_reg[1], 7) ^ rotr(blk_reg[1], 18) ^ (blk_reg[1] >> 3);
        ssig1 = rotr(blk_reg[14], 17) ^ rotr(blk_reg[14], 19) ^ (blk_reg[14] >> 10);
        sched_new = ssig1 + blk_reg[9] + ssig0 + blk_reg[0];
        sig1 = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        sig0 = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        ch   = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        maj  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1   = v_reg[7] + sig1 + ch + ROUND_K[rnd_reg] + blk_reg[0];
        t2   = sig0 + maj;
    end

    // block window: bytes shift in at the low byte of slot 15, rounds shift words out of slot 0
    always_ff @(posedge aclk) begin
        if (cmd.shift_en) begin
            for (int i = 0; i < NUM_WORDS - 1; i++) begin
                blk_reg[i] <= {blk_reg[i][WORD_W-BYTE_W-1:0], blk_reg[i+1][WORD_W-1 -: BYTE_W]};
            end
            blk_reg[NUM_WORDS-1] <= {blk_reg[NUM_WORDS-1][WORD_W-BYTE_W-1:0], in_byte};
        end else if (cmd.round_en) begin
            for (int i = 0; i < NUM_WORDS - 1; i++) begin
                blk_reg[i] <= blk_reg[i+1];
            end
            blk_reg[NUM_WORDS-1] <= sched_new;
        end
    end

    // working variables are preloaded from the hash state on every byte
    always_ff @(posedge aclk) begin
        if (cmd.shift_en) begin
            for (int i = 0; i < NUM_HASH; i++) begin
                v_reg[i] <= h_reg[i];
            end
        end else if (cmd.round_en) begin
            v_reg[0] <= t1 + t2;
            v_reg[1] <= v_reg[0];
            v_reg[2] <= v_reg[1];
            v_reg[3] <= v_reg[2];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[5] <= v_reg[4];
            v_reg[6] <= v_reg[5];
            v_reg[7] <= v_reg[6];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_HASH; i++) begin
                h_reg[i] <= INIT_H[i];
            end
            cnt_reg       <= '0;
            rnd_reg       <= '0;
            len_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.shift_en) begin
                cnt_reg <= cnt_reg + 1'b1;
                rnd_reg <= '0;
            end else if (cmd.round_en) begin
                rnd_reg <= rnd_reg + 1'b1;
            end
            if (cmd.count_len) begin
                len_reg <= len_reg + BYTE_BITS;
            end
            if (cmd.final_add) begin
                for (int i = 0; i < NUM_HASH; i++) begin
                    h_reg[i] <= h_reg[i] + v_reg[i];
                end
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
                idx_reg       <= idx_reg + 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.reinit) begin
                for (int i = 0; i < NUM_HASH; i++) begin
                    h_reg[i] <= INIT_H[i];
                end
                len_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_word_reg <= h_reg[idx_reg];
            out_idx_reg  <= idx_reg;
        end
    end

    assign sts.cnt_last   = (cnt_reg == CNT_LAST);
    assign sts.cnt_at_len = (cnt_reg == CNT_LEN);
    assign sts.round_last = (rnd_reg == RND_LAST);
    assign sts.word_last  = (idx_reg == IDX_LAST);
    assign sts.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - WORD_W - IDX_W){1'b0}}, out_idx_reg, out_word_reg};
    assign m_tlast  = (out_idx_reg == IDX_LAST);

endmodule

`default_nettype wire

// File: hdl/sha256_hash.sv
// byte in: each byte shifts in as it is accepted while idle; every 64th byte starts the round loop and
// then folds the result into the hash state (one round per cycle in the shared round unit)
// last item: one padding/length byte per cycle to the block end, a step without a byte in ST_PAD_ZERO before
// the length bytes, one or two compressions, then 8 words at one per cycle
// while m_tready; the input reopens once the eighth word sits in the output register
// reset: synchronous active-low aresetn restores initial hash values and clears counts
`default_nettype none

module sha256_hash
    import sha256_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // [7:0] data_byte
    input  wire logic                 s_tuser,   // has_byte
    input  wire logic                 s_tlast,   // is_last
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic                      m_tlast    // last_word
);

    dp_cmd_t    cmd;
    dp_status_t sts;

    sha256_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sha256_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .data_byte (s_tdata[BYTE_W-1:0]),
        .cmd       (cmd),
        .sts       (sts),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // a finished message closes the input until the last digest word is loaded into the output register
    a_last_closes_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input still open after the last transaction");

    // the last round is always followed by the hash state update
    a_round_then_add: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.round_en && sts.round_last) |=> cmd.final_add)
        else $error("missing hash update after round 63");

    // tlast flags exactly the eighth digest word
    a_tlast_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tdata[WORD_W+IDX_W-1:WORD_W] == IDX_LAST)))
        else $error("tlast does not match the word index");

endmodule

`default_nettype wire

// File: verif/sha256_checker.sv
// digest checker for the byte-stream sha-256 hasher: watches both stream channels,
// hashes every accepted byte with its own sha-256 and compares each digest word
// depends on sha256_pkg for widths, round constants and initial hash values
module sha256_checker
    import sha256_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,    // [7:0] data_byte
    input  logic                 s_tuser,    // has_byte
    input  logic                 s_tlast,    // is_last
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,    // [31:0] digest_word, [34:32] word_index
    input  logic                 m_tlast,    // last_word
    output int                   fail_count,
    output int                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [IDX_W-1:0]  idx;
        logic              last;
    } digest_t;

    logic [WORD_W-1:0] hs [NUM_HASH];
    logic [WORD_W-1:0] blk [NUM_WORDS];
    logic [CNT_W-1:0]  fill;
    logic [LEN_W-1:0]  nbits;
    digest_t           digest_q [$];
    int                errs = 0;

    function automatic logic [WORD_W-1:0] ror(input logic [WORD_W-1:0] x, input int n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic void compress_block();
        logic [WORD_W-1:0] w [64];
        logic [WORD_W-1:0] v [NUM_HASH];
        logic [WORD_W-1:0] s0, s1, t1, t2;
        for (int i = 0; i < 16; i++) w[i] = blk[i];
        for (int i = 16; i < 64; i++) begin
            s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = s1 + w[i-7] + s0 + w[i-16];
        end
        v = hs;
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < NUM_HASH; i++) hs[i] = hs[i] + v[i];
    endfunction

    // bytes go in big-endian within each block word
    function automatic void place_byte(input logic [CNT_W-1:0] pos, input logic [BYTE_W-1:0] b);
        blk[pos[5:2]][8*(3 - pos[1:0]) +: 8] = b;
    endfunction

    function automatic void clear_block();
        for (int i = 0; i < NUM_WORDS; i++) blk[i] = '0;
    endfunction

    function automatic void hash_item(input logic [BYTE_W-1:0] b, input logic has,
                                      input logic last);
        digest_t d;
        if (has) begin
            place_byte(fill, b);
            nbits = nbits + BYTE_BITS;
            if (fill == CNT_LAST) begin
                compress_block();
                fill = '0;
            end else begin
                fill = fill + 1'b1;
            end
        end
        if (last) begin
            place_byte(fill, PAD_MARK_BYTE);
            for (int i = fill + 1; i < 64; i++) place_byte(i[CNT_W-1:0], '0);
            // no room left for the length field: it goes into an extra block
            if (fill >= CNT_LEN) begin
                compress_block();
                clear_block();
            end
            blk[14] = nbits[63:32];
            blk[15] = nbits[31:0];
            compress_block();
            for (int i = 0; i < NUM_HASH; i++) begin
                d.word = hs[i];
                d.idx  = i[IDX_W-1:0];
                d.last = (i == NUM_HASH - 1);
                digest_q.push_back(d);
            end
            hs    = INIT_H;
            fill  = '0;
            nbits = '0;
        end
    endfunction

    always @(posedge aclk) begin
        digest_t want;
        if (!aresetn) begin
            hs    = INIT_H;
            fill  = '0;
            nbits = '0;
            clear_block();
            digest_q.delete();
        end else begin
            if (s_tvalid && s_tready) hash_item(s_tdata[BYTE_W-1:0], s_tuser, s_tlast);
            if (m_tvalid && m_tready) begin
                if (digest_q.size() == 0) begin
                    errs++;
                    $display("%0t: unexpected digest transaction, expected none, got %h",
                             $time, m_tdata);
                end else begin
                    want = digest_q.pop_front();
                    if (m_tdata[WORD_W-1:0] !== want.word) begin
                        errs++;
                        $display("%0t: digest_word %0d mismatch, expected %h, got %h",
                                 $time, want.idx, want.word, m_tdata[WORD_W-1:0]);
                    end
                    if (m_tdata[WORD_W +: IDX_W] !== want.idx) begin
                        errs++;
                        $display("%0t: word_index mismatch, expected %0d, got %0d",
                                 $time, want.idx, m_tdata[WORD_W +: IDX_W]);
                    end
                    if (m_tlast !== want.last) begin
                        errs++;
                        $display("%0t: last_word mismatch at word %0d, expected %b, got %b",
                                 $time, want.idx, want.last, m_tlast);
                    end
                end
            end
        end
        fail_count <= errs;
        pending    <= digest_q.size();
    end

endmodule

// File: verif/tb.sv
// top-level bench for sha256_hash: resets the block, sends directed and random byte
// messages with random gaps and back-pressure, and reports the verdict
// depends on sha256_pkg, sha256_hash and sha256_checker
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sha256_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 150;
    localparam int ITEM_TARGET = 220;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // [7:0] data_byte
    logic                 s_tuser  = 1'b0; // has_byte
    logic                 s_tlast  = 1'b0; // is_last
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // [31:0] digest_word, [34:32] word_index
    logic                 m_tlast;         // last_word

    int   fail_count;
    int   pending;
    int   sent      = 0;
    int   cycles    = 0;
    logic calm      = 1'b0;
    logic want_hold = 1'b0;

    sha256_hash i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    sha256_checker i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("FAIL");
        $finish;
    end

    // result side: random back-pressure, one long hold-off on request
    initial begin
        bit held;
        held = 1'b0;
        forever begin
            @(posedge aclk);
            if (want_hold && !held) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_tready <= calm || ($urandom_range(0, 99) >= 33);
        end
    end

    task automatic send_item(input logic [BYTE_W-1:0] b, input logic has, input logic last);
        while (!calm && $urandom_range(0, 99) < 33) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= has;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
    endtask

    // the checker's count is registered, so it trails the last transaction
    task automatic drain_digests();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic send_message(input int len, input logic force_calm);
        bit split_end;
        split_end = (len == 0) || ($urandom_range(0, 2) == 0);
        calm <= force_calm || ($urandom_range(0, 4) == 0);
        for (int i = 0; i < len; i++) begin
            // stray empty transaction, ignored by the block
            if ($urandom_range(0, 9) == 0) begin
                send_item(8'($urandom), 1'b0, 1'b0);
                sent++;
            end
            send_item(8'($urandom), 1'b1, !split_end && (i == len - 1));
            sent++;
        end
        if (split_end) begin
            send_item(8'($urandom), 1'b0, 1'b1);
            sent++;
        end
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return $urandom_range(0, 10);
        if (r < 85) begin
            // lengths around the one- and two-block padding boundaries
            case ($urandom_range(0, 7))
                0: return 55;
                1: return 56;
                2: return 57;
                3: return 63;
                4: return 64;
                5: return 65;
                6: return 119;
                default: return 120;
            endcase
        end
        return $urandom_range(11, 54);
    endfunction

    initial begin
        int msgs;
        msgs = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty message, then a lone zero byte carrying the end flag
        send_item(8'h5a, 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        // byte, ignored transaction, separate empty end
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h3c, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        // "abc"
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'hff, 1'b1, 1'b1);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h7f, 1'b1, 1'b0);
        send_item(8'h55, 1'b1, 1'b0);
        send_item(8'haa, 1'b1, 1'b1);
        sent = 13;

        // sender waits for every digest before going on
        drain_digests();

        // receiver stalls for a long stretch while short messages come first, then random lengths up to 120 bytes
        want_hold <= 1'b1;
        while (sent < ITEM_TARGET) begin
            if (msgs == 4) send_message(120, 1'b1);
            else if (msgs < 3) send_message($urandom_range(0, 6), 1'b0);
            else send_message(pick_len(), 1'b0);
            msgs++;
        end

        drain_digests();
        repeat (SETTLE) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
